>>> hdl/lld_pkg.sv
// Shared types, constants and the presence test for the lane line hold/debounce block.
package lld_pkg;

    // Q16.16 word width and the width of the lane index field
    localparam int unsigned COEF_W = 32;
    localparam int unsigned LANE_W = 3;
    localparam int unsigned THR_W  = 8;
    localparam int unsigned MISS_W = 8;
    localparam int unsigned FLIP_W = 9;

    // Threshold register value after reset
    localparam logic [THR_W-1:0] HOLD_THRESHOLD_RESET = 8'd5;

    // Bias that maps -65535..65535 onto 0..131070 for the presence test
    localparam logic [COEF_W-1:0] PRESENT_BIAS = 32'd65535;
    localparam logic [COEF_W-1:0] PRESENT_SPAN = 32'd131070;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } line_t;

    localparam line_t ZERO_LINE = '{a: '0, b: '0, c: '0};

    typedef struct packed {
        line_t             prev;
        logic [MISS_W-1:0] miss_count;
        logic [FLIP_W-1:0] flip_count;
        logic              buffered_presence;
    } lane_state_t;

    // A line is present when the integer part of c is nonzero
    function automatic logic line_present(input logic [COEF_W-1:0] c);
        logic [COEF_W-1:0] biased;
        begin
            biased = c + PRESENT_BIAS;
            return biased > PRESENT_SPAN;
        end
    endfunction

endpackage

>>> hdl/lane_line_hold_debounce_top.sv
// Top level: input register, per-lane state bank, lane update and result register.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   cfg     | cfg_we, cfg_wdata (hold_threshold)             | in
//   in      | in_valid/in_ready, lane, line_a/b/c            | in
//   out     | out_valid/out_ready, out_lane, out_a/b/c,      | out
//           | debounced_present                              |
//
// One item per cycle sustained while the output is not stalled; an accepted item waits in
// the input register, where the lane read-modify-write runs on it, then moves on into
// the result register when the result slot frees up.
// The lane state is read and written back in the same cycle, so consecutive items on
// one lane need no forwarding. Reset clears all lane state and sets the threshold to 5.
// A stalled output holds its item while the input register still takes one more.
module lane_line_hold_debounce_top
#(
    parameter int NUM_LANES = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lld_pkg::THR_W-1:0]         cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lld_pkg::LANE_W-1:0]        lane,
    input  logic signed [lld_pkg::COEF_W-1:0] line_a,
    input  logic signed [lld_pkg::COEF_W-1:0] line_b,
    input  logic signed [lld_pkg::COEF_W-1:0] line_c,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lld_pkg::LANE_W-1:0]        out_lane,
    output logic signed [lld_pkg::COEF_W-1:0] out_a,
    output logic signed [lld_pkg::COEF_W-1:0] out_b,
    output logic signed [lld_pkg::COEF_W-1:0] out_c,
    output logic                              debounced_present
);

    // Only lanes reachable through the lane field get storage
    localparam int LANE_SPAN = 1 << lld_pkg::LANE_W;
    localparam int DEPTH     = (NUM_LANES < LANE_SPAN) ? NUM_LANES : LANE_SPAN;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [lld_pkg::THR_W-1:0]  hold_threshold_reg;

    logic                       in_valid_reg;
    logic [lld_pkg::LANE_W-1:0] in_lane_reg;
    lld_pkg::line_t             in_line_reg;

    logic                       out_valid_reg;
    logic [lld_pkg::LANE_W-1:0] out_lane_reg;
    lld_pkg::line_t             out_line_reg;
    logic                       out_flag_reg;

    lld_pkg::lane_state_t       state_reg [DEPTH];

    logic                       advance;
    logic                       lane_ok;
    logic [IDX_W-1:0]           idx;
    lld_pkg::lane_state_t       st_cur;
    lld_pkg::lane_state_t       state_next;
    lld_pkg::line_t             line_next;
    logic                       flag_next;

    // Handshake: move the input register forward when the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Select the lane state
    assign lane_ok = (int'(in_lane_reg) < NUM_LANES);
    assign idx     = IDX_W'(in_lane_reg);
    assign st_cur  = lane_ok ? state_reg[idx] : '0;

    lld_step u_step
    (
        .line_in        (in_line_reg),
        .st_in          (st_cur),
        .hold_threshold (hold_threshold_reg),
        .lane_ok        (lane_ok),
        .line_out       (line_next),
        .flag           (flag_next),
        .st_out         (state_next)
    );

    // Hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_threshold_reg <= lld_pkg::HOLD_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            hold_threshold_reg <= cfg_wdata;
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_lane_reg   <= lane;
            in_line_reg.a <= line_a;
            in_line_reg.b <= line_b;
            in_line_reg.c <= line_c;
        end
    end

    // Write back the lane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                state_reg[k] <= '0;
            end
        end
        else if (advance && lane_ok)
        begin
            state_reg[idx] <= state_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_lane_reg <= in_lane_reg;
            out_line_reg <= line_next;
            out_flag_reg <= flag_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_lane          = out_lane_reg;
    assign out_a             = out_line_reg.a;
    assign out_b             = out_line_reg.b;
    assign out_c             = out_line_reg.c;
    assign debounced_present = out_flag_reg;

endmodule

>>> hdl/lld_step.sv
// Combinational update of one lane: miss hold, presence debounce and final line select.
module lld_step
(
    input  lld_pkg::line_t             line_in,
    input  lld_pkg::lane_state_t       st_in,
    input  logic [lld_pkg::THR_W-1:0]  hold_threshold,
    input  logic                       lane_ok,
    output lld_pkg::line_t             line_out,
    output logic                       flag,
    output lld_pkg::lane_state_t       st_out
);

    logic                          raw_present;
    logic [lld_pkg::MISS_W-1:0]    miss_inc;
    lld_pkg::line_t                line_mid;
    logic                          flag_mid;

    always_comb
    begin
        st_out      = st_in;
        raw_present = lld_pkg::line_present(line_in.c);
        line_mid    = line_in;
        miss_inc    = st_in.miss_count + 1'b1;

        // Hold the previous line while the incremented miss counter is below threshold
        if (!raw_present)
        begin
            if (miss_inc < hold_threshold)
            begin
                st_out.miss_count = miss_inc;
                line_mid          = st_in.prev;
            end
            else
            begin
                st_out.miss_count = '0;
            end
        end

        // Debounce a change in presence with the flip counter
        flag_mid = raw_present;
        if (st_in.buffered_presence != raw_present)
        begin
            if (st_in.flip_count <= {1'b0, hold_threshold})
            begin
                flag_mid          = st_in.buffered_presence;
                st_out.flip_count = st_in.flip_count + 1'b1;
            end
            else
            begin
                st_out.flip_count        = '0;
                st_out.buffered_presence = raw_present;
            end
        end
        else
        begin
            st_out.flip_count = '0;
        end

        // Still empty: hold from previous output or drop to zero
        if (!lld_pkg::line_present(line_mid.c))
        begin
            line_mid = flag_mid ? st_in.prev : lld_pkg::ZERO_LINE;
        end
        st_out.prev = line_mid;

        // Lanes with no storage pass the item through untouched
        if (lane_ok)
        begin
            line_out = line_mid;
            flag     = flag_mid;
        end
        else
        begin
            line_out = line_in;
            flag     = raw_present;
        end
    end

endmodule
